// ===== rtl/cwsl_pkg.sv =====
// Package of the clocked word-serial link: transaction types, register codes
// and widths shared by the front, queue, back and top-level modules.
// Depends on nothing.
package cwsl_pkg;

  localparam int WORD_BITS = 16;
  localparam int BIT_CNT_W = $clog2(WORD_BITS + 1);
  localparam int TAIL_W = 6;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [TAIL_W-1:0] TAIL_RESET = 6'd30;
  localparam logic RELEASE_RESET = 1'b1;

  // Register select taken from byte address bit 2.
  localparam logic REG_TAIL = 1'b0;
  localparam logic REG_RELEASE = 1'b1;

  typedef struct packed {
    logic        link_clock;
    logic        slave_ready;
    logic        tx_valid;
    logic [15:0] tx_word;
    logic        tx_is_command;
    logic        tx_last;
    logic        transfer_strobe;
    logic        valid_word_strobe;
    logic        word_kind_pin;
    logic [15:0] parallel_data;
  } in_item_t;

  typedef struct packed {
    logic        enable_line;
    logic        select_line;
    logic        serial_out;
    logic        output_enable;
    logic        tx_taken;
    logic        frame_done;
    logic        rx_valid;
    logic        rx_kind;
    logic [15:0] rx_data;
  } out_item_t;

  // One classified tick as it waits between the front and the back.
  typedef struct packed {
    logic        link_clock;
    logic        slave_ready;
    logic        tx_valid;
    logic [15:0] tx_word;
    logic        tx_is_command;
    logic        tx_last;
    logic        strobe_rise;
    logic        word_fall;
    logic        word_kind_pin;
    logic [15:0] parallel_data;
  } tick_t;

  typedef struct packed {
    logic [TAIL_W-1:0] tail_clock_periods;
    logic              release_output_enable;
  } cfg_t;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_START_HI,
    PH_START_LO,
    PH_READY,
    PH_BIT_LO,
    PH_BIT_HI,
    PH_GAP_LO,
    PH_GAP_HI,
    PH_NEXT,
    PH_TAIL_LO,
    PH_TAIL_HI
  } tx_phase_e;

endpackage

// ===== rtl/cwsl_front.sv =====
// Front part of the link: accepts sampled-pin transactions and classifies the
// receive strobe edges. Depends on cwsl_pkg.
module cwsl_front import cwsl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  in_item_t in_item_i,
  output logic     in_stall_o,
  input  logic     queue_full_i,
  output logic     push_o,
  output tick_t    tick_o
);

  logic prev_td_q, prev_td_d;
  logic prev_vw_q, prev_vw_d;

  assign in_stall_o = queue_full_i;
  assign push_o = in_valid_i && !queue_full_i;

  always_comb begin
    prev_td_d = prev_td_q;
    prev_vw_d = prev_vw_q;
    if (push_o) begin
      prev_td_d = in_item_i.transfer_strobe;
      prev_vw_d = in_item_i.valid_word_strobe;
    end
  end

  always_comb begin
    tick_o.link_clock    = in_item_i.link_clock;
    tick_o.slave_ready   = in_item_i.slave_ready;
    tick_o.tx_valid      = in_item_i.tx_valid;
    tick_o.tx_word       = in_item_i.tx_word;
    tick_o.tx_is_command = in_item_i.tx_is_command;
    tick_o.tx_last       = in_item_i.tx_last;
    tick_o.strobe_rise   = !prev_td_q && in_item_i.transfer_strobe;
    tick_o.word_fall     = prev_vw_q && !in_item_i.valid_word_strobe;
    tick_o.word_kind_pin = in_item_i.word_kind_pin;
    tick_o.parallel_data = in_item_i.parallel_data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_td_q <= 1'b0;
      prev_vw_q <= 1'b0;
    end else begin
      prev_td_q <= prev_td_d;
      prev_vw_q <= prev_vw_d;
    end
  end

endmodule

// ===== rtl/cwsl_queue.sv =====
// Short queue of classified transactions between the front and the back.
// Depends on cwsl_pkg.
module cwsl_queue import cwsl_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  tick_t push_data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  not_empty_o,
  output tick_t pop_data_o
);

  tick_t mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CNT_W-1:0] count_q, count_d;

  assign full_o = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign not_empty_o = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q <= count_d;
    end
  end

endmodule

// ===== rtl/cwsl_back.sv =====
// Back part of the link: runs the transmit sequencer and the receive capture
// for each queued transaction and holds the result register. Depends on cwsl_pkg.
module cwsl_back import cwsl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      tick_valid_i,
  input  tick_t     tick_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  tx_phase_e phase_q, phase_d;
  logic [BIT_CNT_W-1:0] bit_cnt_q, bit_cnt_d, bit_cnt_inc;
  logic [WORD_BITS-1:0] shift_q, shift_d;
  logic [TAIL_W-1:0] tail_cnt_q, tail_cnt_d, tail_cnt_inc;
  logic last_q, last_d;
  logic cmd_q, cmd_d;
  logic en_q, en_d;
  logic sel_q, sel_d;
  logic sdo_q, sdo_d;
  logic oi_q, oi_d;
  logic armed_q, armed_d;
  logic kind_q, kind_d;
  logic out_valid_q, out_valid_d;
  out_item_t out_q, out_d;
  logic taken, done, word_done, tail_done;

  assign pop_o = tick_valid_i && (!out_valid_q || !out_stall_i);
  assign bit_cnt_inc = bit_cnt_q + 1'b1;
  assign tail_cnt_inc = tail_cnt_q + 1'b1;
  assign word_done = (bit_cnt_inc >= BIT_CNT_W'(WORD_BITS));
  assign tail_done = (tail_cnt_inc >= cfg_i.tail_clock_periods);

  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      PH_IDLE: begin
        if (tick_i.tx_valid) phase_d = PH_START_HI;
      end
      PH_START_HI: begin
        if (tick_i.link_clock) phase_d = PH_START_LO;
      end
      PH_START_LO: begin
        if (!tick_i.link_clock) phase_d = PH_READY;
      end
      PH_READY: begin
        if (tick_i.slave_ready) phase_d = PH_BIT_LO;
      end
      PH_BIT_LO: begin
        if (!tick_i.link_clock) phase_d = PH_BIT_HI;
      end
      PH_BIT_HI: begin
        if (tick_i.link_clock) phase_d = word_done ? PH_GAP_LO : PH_BIT_LO;
      end
      PH_GAP_LO: begin
        if (!tick_i.link_clock) phase_d = PH_GAP_HI;
      end
      PH_GAP_HI: begin
        if (tick_i.link_clock) begin
          if (!last_q) begin
            phase_d = PH_NEXT;
          end else if (cfg_i.tail_clock_periods == '0) begin
            phase_d = PH_IDLE;
          end else begin
            phase_d = PH_TAIL_LO;
          end
        end
      end
      PH_NEXT: begin
        if (tick_i.tx_valid) phase_d = PH_READY;
      end
      PH_TAIL_LO: begin
        if (!tick_i.link_clock) phase_d = PH_TAIL_HI;
      end
      PH_TAIL_HI: begin
        if (tick_i.link_clock) phase_d = tail_done ? PH_IDLE : PH_TAIL_LO;
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_comb begin
    bit_cnt_d = bit_cnt_q;
    shift_d = shift_q;
    tail_cnt_d = tail_cnt_q;
    last_d = last_q;
    cmd_d = cmd_q;
    en_d = en_q;
    sel_d = sel_q;
    sdo_d = sdo_q;
    oi_d = oi_q;
    taken = 1'b0;
    done = 1'b0;
    case (phase_q)
      PH_IDLE: begin
        if (tick_i.tx_valid) begin
          shift_d = WORD_BITS'(tick_i.tx_word);
          cmd_d = tick_i.tx_is_command;
          last_d = tick_i.tx_last;
          taken = 1'b1;
          oi_d = 1'b1;
        end
      end
      PH_START_HI: begin
        if (tick_i.link_clock) en_d = 1'b1;
      end
      PH_START_LO: begin
        if (!tick_i.link_clock) sel_d = cmd_q;
      end
      PH_READY: begin
        if (tick_i.slave_ready) bit_cnt_d = '0;
      end
      PH_BIT_LO: begin
        if (!tick_i.link_clock) sdo_d = shift_q[WORD_BITS-1];
      end
      PH_BIT_HI: begin
        if (tick_i.link_clock) begin
          bit_cnt_d = bit_cnt_inc;
          shift_d = {shift_q[WORD_BITS-2:0], 1'b0};
        end
      end
      PH_GAP_HI: begin
        if (tick_i.link_clock && last_q) begin
          en_d = 1'b0;
          tail_cnt_d = '0;
          if (cfg_i.tail_clock_periods == '0) begin
            done = 1'b1;
            if (cfg_i.release_output_enable) oi_d = 1'b0;
          end
        end
      end
      PH_NEXT: begin
        if (tick_i.tx_valid) begin
          shift_d = WORD_BITS'(tick_i.tx_word);
          cmd_d = tick_i.tx_is_command;
          last_d = tick_i.tx_last;
          taken = 1'b1;
          sel_d = tick_i.tx_is_command;
        end
      end
      PH_TAIL_HI: begin
        if (tick_i.link_clock) begin
          tail_cnt_d = tail_cnt_inc;
          if (tail_done) begin
            done = 1'b1;
            if (cfg_i.release_output_enable) oi_d = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    armed_d = armed_q;
    kind_d = kind_q;
    out_d.rx_valid = 1'b0;
    out_d.rx_kind = 1'b0;
    out_d.rx_data = '0;
    if (tick_i.word_fall && armed_q) begin
      out_d.rx_valid = 1'b1;
      out_d.rx_kind = kind_q;
      out_d.rx_data = tick_i.parallel_data;
      armed_d = 1'b0;
    end
    if (tick_i.strobe_rise && (phase_q == PH_IDLE)) begin
      kind_d = tick_i.word_kind_pin;
      armed_d = 1'b1;
    end
    out_d.enable_line = en_d;
    out_d.select_line = sel_d;
    out_d.serial_out = sdo_d;
    out_d.output_enable = oi_d;
    out_d.tx_taken = taken;
    out_d.frame_done = done;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o = out_q;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      bit_cnt_q <= '0;
      shift_q <= '0;
      tail_cnt_q <= '0;
      last_q <= 1'b0;
      cmd_q <= 1'b0;
      en_q <= 1'b0;
      sel_q <= 1'b0;
      sdo_q <= 1'b0;
      oi_q <= 1'b0;
      armed_q <= 1'b0;
      kind_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        phase_q <= phase_d;
        bit_cnt_q <= bit_cnt_d;
        shift_q <= shift_d;
        tail_cnt_q <= tail_cnt_d;
        last_q <= last_d;
        cmd_q <= cmd_d;
        en_q <= en_d;
        sel_q <= sel_d;
        sdo_q <= sdo_d;
        oi_q <= oi_d;
        armed_q <= armed_d;
        kind_q <= kind_d;
      end
    end
  end

endmodule

// ===== rtl/clocked_word_serial_link.sv =====
// Clocked word-serial link: one transaction carries one cycle's sampled pins
// and an offered transmit word, and returns one result with the pin drives.
// The block takes one transaction per cycle while in_stall_o is low; a result
// is presented once its transaction has passed the two-entry queue between
// the edge-classifying front and the transmit/receive back, and then the
// result register at the back. While a result is stalled the queue takes
// transactions until its two entries are full, and then in_stall_o rises.
// The tail length and the OI release are set over the register port.
// Depends on cwsl_pkg, cwsl_front, cwsl_queue and cwsl_back.
module clocked_word_serial_link import cwsl_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_item_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t cfg_q, cfg_d;
  logic cfg_write;
  logic push, queue_full, pop, queue_not_empty;
  tick_t push_tick, pop_tick;

  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_write) begin
      case (paddr[2])
        REG_TAIL: cfg_d.tail_clock_periods = pwdata[TAIL_W-1:0];
        REG_RELEASE: cfg_d.release_output_enable = pwdata[0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_TAIL: prdata = APB_DATA_W'(cfg_q.tail_clock_periods);
      REG_RELEASE: prdata = APB_DATA_W'(cfg_q.release_output_enable);
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tail_clock_periods <= TAIL_RESET;
      cfg_q.release_output_enable <= RELEASE_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  cwsl_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_item_i    (in_item_i),
    .in_stall_o   (in_stall_o),
    .queue_full_i (queue_full),
    .push_o       (push),
    .tick_o       (push_tick)
  );

  cwsl_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_tick),
    .full_o      (queue_full),
    .pop_i       (pop),
    .not_empty_o (queue_not_empty),
    .pop_data_o  (pop_tick)
  );

  cwsl_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .tick_valid_i (queue_not_empty),
    .tick_i       (pop_tick),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_o   (out_item_o)
  );

endmodule
